@@ rtl/core/memory_quota_accounting_unit_macros.svh @@
// assertion macros for the memory quota accounting checker
`ifndef MEMORY_QUOTA_ACCOUNTING_UNIT_MACROS_SVH
`define MEMORY_QUOTA_ACCOUNTING_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define MQA_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define MQA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mqa_pkg.sv @@
// shared types, constants and helpers of the memory quota accounting unit
package mqa_pkg;

   localparam int CONTEXT_COUNT = 32;
   localparam int HOLD_WIDTH    = 48;

   localparam int AMOUNT_W      = 48;
   localparam int CTXREQ_W      = 8;
   localparam int LIMIT_W       = 47;
   localparam int CACHE_CTX_W   = 5;
   localparam int COUNT_W       = 32;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 47;
   localparam int STATUS_W      = 2;

   localparam int CTX_W = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;
   localparam int CMP_W = ((HOLD_WIDTH > AMOUNT_W) ? HOLD_WIDTH : AMOUNT_W) + 1;

   localparam int QUEUE_DEPTH     = 2;
   // queue entries plus the item in the back end plus the output register
   localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 2;

   localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {1'b0, {(HOLD_WIDTH-1){1'b1}}};
   localparam logic [LIMIT_W-1:0]    GLOBAL_LIMIT_RESET = {LIMIT_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_GLOBAL_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CACHE_CONTEXT = 1'b1;

   localparam logic KIND_AMOUNT    = 1'b0;
   localparam logic KIND_SET_LIMIT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_GLOBAL    = 2'd1,
      STATUS_CONTEXT   = 2'd2,
      STATUS_INVALID   = 2'd3
   } status_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic                  kind;
      logic [CTXREQ_W-1:0]   ctx_raw;
      logic                  ctx_ok;
      logic                  amount_pos;
      logic                  amount_zero;
      logic                  check;
      logic                  to_cache;
      logic                  set_bad;
      logic [HOLD_WIDTH-1:0] value;
   } mqa_op_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]     global_limit;
      logic [CACHE_CTX_W-1:0] cache_ctx;
   } mqa_csr_type;

   typedef struct packed {
      logic [HOLD_WIDTH-1:0] limit;
      logic [HOLD_WIDTH-1:0] held;
   } mqa_entry_type;

   function automatic logic [HOLD_WIDTH-1:0] to_hold(input logic signed [AMOUNT_W-1:0] v);
      to_hold = HOLD_WIDTH'(v);
   endfunction

   function automatic logic [AMOUNT_W-1:0] hold_to_out(input logic [HOLD_WIDTH-1:0] h);
      hold_to_out = AMOUNT_W'($signed(h));
   endfunction

endpackage

@@ rtl/core/mqa_ram.sv @@
// generic single-write, single-read ram with registered read data
module mqa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mqa_front.sv @@
// front end: takes request transactions and classifies them for the back end
module mqa_front import mqa_pkg::*; (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [CTXREQ_W-1:0]        req_context_req,
   input  logic signed [AMOUNT_W-1:0] req_amount,
   input  logic                       req_high_priority,
   input  logic                       req_to_cache,
   input  logic                       q_full,
   output logic                       push,
   output mqa_op_type                 push_op
);

   logic amount_pos;
   logic amount_zero;
   logic ctx_ok;
   logic limit_sat;

   always_comb begin
      amount_zero = (req_amount == '0);
      amount_pos  = !req_amount[AMOUNT_W-1] && !amount_zero;
      ctx_ok      = ({1'b0, req_context_req} < (CTXREQ_W+1)'(CONTEXT_COUNT));
      // a new limit above the largest positive hold saturates
      limit_sat   = $signed(CMP_W'(req_amount)) > $signed(CMP_W'(HOLD_MAX));

      push_op.kind        = req_kind;
      push_op.ctx_raw     = req_context_req;
      push_op.ctx_ok      = ctx_ok;
      push_op.amount_pos  = amount_pos;
      push_op.amount_zero = amount_zero;
      push_op.check       = amount_pos && !req_high_priority;
      push_op.to_cache    = req_to_cache;
      push_op.set_bad     = !ctx_ok || !amount_pos;
      if ((req_kind == KIND_SET_LIMIT) && limit_sat) begin
         push_op.value = HOLD_MAX;
      end else begin
         push_op.value = to_hold(req_amount);
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

endmodule

@@ rtl/core/mqa_queue.sv @@
// short fifo of classified transactions between front and back
module mqa_queue import mqa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  mqa_op_type push_op,
   input  logic       pop,
   output mqa_op_type pop_op,
   output logic       full,
   output logic       empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mqa_op_type       entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign pop_op = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ rtl/core/mqa_back.sv @@
// back end: context table read-modify-write, limit checks and result register
module mqa_back import mqa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  mqa_csr_type         csr,
   input  logic                q_empty,
   input  mqa_op_type          q_op,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [AMOUNT_W-1:0] rsp_total_hold,
   output logic [AMOUNT_W-1:0] rsp_context_hold,
   output logic [AMOUNT_W-1:0] rsp_cache_hold,
   output logic [COUNT_W-1:0]  rsp_cache_items
);

   typedef enum logic [1:0] {
      ST_ISSUE = 2'b01,
      ST_EXEC  = 2'b10
   } back_state_type;

   back_state_type        state_ff, state_in;
   mqa_op_type            op_ff;
   logic                  entry_ok_ff, entry_ok_in;
   logic [CONTEXT_COUNT-1:0] written_ff, written_in;

   logic [HOLD_WIDTH-1:0] total_ff, total_in;
   logic [HOLD_WIDTH-1:0] cache_ff, cache_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, status_in;
   logic [HOLD_WIDTH-1:0] rsp_total_ff;
   logic [HOLD_WIDTH-1:0] rsp_held_ff, held_out;
   logic                  rsp_incl_ff, incl_in;
   logic [HOLD_WIDTH-1:0] rsp_cache_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [CTX_W-1:0]      rd_addr;
   logic [CTX_W-1:0]      op_addr;
   mqa_entry_type         rd_entry;
   mqa_entry_type         cur_entry;
   mqa_entry_type         wr_entry;
   logic                  wr_en;
   logic                  out_free;
   logic                  exec_go;
   logic [HOLD_WIDTH-1:0] new_total;
   logic [HOLD_WIDTH-1:0] new_held;
   logic [HOLD_WIDTH-1:0] new_cache;
   logic                  global_fail;
   logic                  context_fail;

   assign rd_addr  = q_op.ctx_raw[CTX_W-1:0];
   assign op_addr  = op_ff.ctx_raw[CTX_W-1:0];
   assign pop      = (state_ff == ST_ISSUE) && !q_empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign exec_go  = (state_ff == ST_EXEC) && out_free;

   mqa_ram #(
      .WIDTH($bits(mqa_entry_type)),
      .DEPTH(CONTEXT_COUNT)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(op_addr),
      .wr_data(wr_entry),
      .rd_en  (pop),
      .rd_addr(rd_addr),
      .rd_data(rd_entry)
   );

   always_comb begin
      // entries never written read as zero hold and no limit
      if (entry_ok_ff) begin
         cur_entry = rd_entry;
      end else begin
         cur_entry.limit = HOLD_MAX;
         cur_entry.held  = '0;
      end

      new_total = total_ff + op_ff.value;
      new_held  = cur_entry.held + op_ff.value;
      new_cache = cache_ff + op_ff.value;

      global_fail  = op_ff.check &&
                     ($signed(CMP_W'($signed(new_total))) > $signed(CMP_W'(csr.global_limit)));
      context_fail = op_ff.check && ($signed(new_held) > $signed(cur_entry.limit));

      status_in = STATUS_OK;
      total_in  = total_ff;
      cache_in  = cache_ff;
      count_in  = count_ff;
      wr_entry  = cur_entry;
      wr_en     = 1'b0;

      if (op_ff.kind == KIND_SET_LIMIT) begin
         if (op_ff.set_bad) begin
            status_in = STATUS_INVALID;
         end else begin
            wr_entry.limit = op_ff.value;
            wr_en          = exec_go;
         end
      end else if (global_fail) begin
         status_in = STATUS_GLOBAL;
      end else if (!op_ff.to_cache) begin
         if (!op_ff.ctx_ok) begin
            status_in = STATUS_INVALID;
         end else if (context_fail) begin
            status_in = STATUS_CONTEXT;
         end else begin
            wr_entry.held = new_held;
            wr_en         = exec_go;
            total_in      = new_total;
         end
      end else begin
         total_in = new_total;
         if (!op_ff.amount_zero) begin
            cache_in = new_cache;
            count_in = op_ff.amount_pos ? count_ff + 1'b1 : count_ff - 1'b1;
         end
      end

      held_out = op_ff.ctx_ok ? wr_entry.held : '0;
      incl_in  = op_ff.ctx_ok && (op_ff.ctx_raw == CTXREQ_W'(csr.cache_ctx));
   end

   always_comb begin
      state_in    = state_ff;
      entry_ok_in = entry_ok_ff;
      written_in  = written_ff;
      case (state_ff)
         ST_ISSUE: begin
            if (pop) begin
               state_in    = ST_EXEC;
               entry_ok_in = q_op.ctx_ok && written_ff[rd_addr];
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_ISSUE;
            end
            if (wr_en) begin
               written_in[op_addr] = 1'b1;
            end
         end
         default: begin
            state_in = ST_ISSUE;
         end
      endcase

      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         entry_ok_ff  <= 1'b0;
         written_ff   <= '0;
         total_ff     <= '0;
         cache_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_ok_ff  <= entry_ok_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            total_ff <= total_in;
            cache_ff <= cache_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= q_op;
      end
      if (exec_go) begin
         rsp_status_ff <= status_in;
         rsp_total_ff  <= total_in;
         rsp_held_ff   <= held_out;
         rsp_incl_ff   <= incl_in;
         rsp_cache_ff  <= cache_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_total_hold   = hold_to_out(rsp_total_ff);
   assign rsp_context_hold = hold_to_out(rsp_held_ff + (rsp_incl_ff ? rsp_cache_ff : '0));
   assign rsp_cache_hold   = hold_to_out(rsp_cache_ff);
   assign rsp_cache_items  = rsp_count_ff;

endmodule

@@ rtl/core/memory_quota_accounting_unit.sv @@
// top level of the memory quota accounting unit
//
// usage:
// - req channel: one transaction either charges or releases a signed byte amount
//   against a context (or the cache), or sets the hard limit of one context
// - rsp channel: exactly one result transaction per request, in request order,
//   with a status code and the total, context and cache holds after the request
// - csr port: csr_write with csr_index 0 sets the global hard limit, index 1 the
//   cache context; write only while no request is in flight
// - path: queue entry, context table read, then the output register to rsp_valid
// - the back end pops a new request only after the read-modify-write of the last:
//   the context table ram is read on issue, checked and written back on exec
// - a two-entry queue sits between the classifier and the execution side, so
//   up to two further requests are taken while one executes
// - reset: holds, cache count and queue clear, every context reads as zero hold
//   with no limit, global limit goes to its maximum, cache context to zero;
//   requests are taken from the first cycle after reset
// - rsp_stall: the result waits in the output register, execution pauses and
//   req_stall rises once the queue is full
module memory_quota_accounting_unit import mqa_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // request transactions
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [CTXREQ_W-1:0]        req_context_req,
   input  logic signed [AMOUNT_W-1:0] req_amount,
   input  logic                       req_high_priority,
   input  logic                       req_to_cache,
   // result transactions
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [AMOUNT_W-1:0] rsp_total_hold,
   output logic signed [AMOUNT_W-1:0] rsp_context_hold,
   output logic signed [AMOUNT_W-1:0] rsp_cache_hold,
   output logic signed [COUNT_W-1:0]  rsp_cache_items,
   // register writes
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   mqa_csr_type csr_ff, csr_in;

   logic       push;
   mqa_op_type push_op;
   logic       q_full;
   logic       q_empty;
   logic       pop;
   mqa_op_type q_op;

   // configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_GLOBAL_LIMIT:  csr_in.global_limit = csr_data[LIMIT_W-1:0];
            CSR_CACHE_CONTEXT: csr_in.cache_ctx    = csr_data[CACHE_CTX_W-1:0];
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.global_limit <= GLOBAL_LIMIT_RESET;
         csr_ff.cache_ctx    <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // classify incoming transactions
   mqa_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_context_req  (req_context_req),
      .req_amount       (req_amount),
      .req_high_priority(req_high_priority),
      .req_to_cache     (req_to_cache),
      .q_full           (q_full),
      .push             (push),
      .push_op          (push_op)
   );

   // decouple front from back
   mqa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .push_op(push_op),
      .pop    (pop),
      .pop_op (q_op),
      .full   (q_full),
      .empty  (q_empty)
   );

   // execute against the context table and hold counters
   mqa_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr_ff),
      .q_empty         (q_empty),
      .q_op            (q_op),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_total_hold  (rsp_total_hold),
      .rsp_context_hold(rsp_context_hold),
      .rsp_cache_hold  (rsp_cache_hold),
      .rsp_cache_items (rsp_cache_items)
   );

endmodule

@@ rtl/core/mqa_checker.sv @@
// port-level assertions for the memory quota accounting unit, with bind
`include "memory_quota_accounting_unit_macros.svh"

module mqa_checker import mqa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [AMOUNT_W-1:0] rsp_total_hold,
   input logic [AMOUNT_W-1:0] rsp_context_hold,
   input logic [AMOUNT_W-1:0] rsp_cache_hold,
   input logic [COUNT_W-1:0]  rsp_cache_items
);

   localparam int OUT_W = $clog2(MAX_OUTSTANDING + 1);

   logic [OUT_W-1:0] outstanding_ff, outstanding_in;
   logic             req_take;
   logic             rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `MQA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_total_hold) &&
      $stable(rsp_context_hold) && $stable(rsp_cache_hold) && $stable(rsp_cache_items),
      "stalled result changed")
   `MQA_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, outstanding_ff != '0,
      "result without a pending request")
   `MQA_ASSERT_IMPLY(a_bounded, clock, reset, 1'b1,
      outstanding_ff <= OUT_W'(MAX_OUTSTANDING), "too many requests in flight")
   `MQA_ASSERT_IMPLY(a_reset_quiet, clock, reset, $fell(reset), !rsp_valid,
      "result right after reset")

endmodule

bind memory_quota_accounting_unit mqa_checker u_mqa_checker (.*);
